// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the Jacobi symbol unit.
package jsu_pkg;

  // Symbol codes, two's complement on two bits.
  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  // Control from the sequencer to the bit-serial divider.
  typedef struct packed {
    logic start;
  } jsu_div_ctl_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic done;
  } jsu_div_sts_t;

endpackage

// ===== rtl/jsu_div.sv =====
// Restoring bit-serial remainder unit: one quotient bit per cycle.
module jsu_div import jsu_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_div_ctl_t       ctl,
  input  logic [WIDTH-1:0]   dividend,
  input  logic [WIDTH-1:0]   divisor,
  output jsu_div_sts_t       sts,
  output logic [WIDTH-1:0]   remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] shf_r, shf_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  always_comb begin
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, shf_r[WIDTH-1]};
    diff     = trial - {1'b0, dvs_r};
    if (ctl.start) begin
      shf_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CW'(WIDTH);
      run_nxt = 1'b1;
    end else if (run_r) begin
      shf_nxt = {shf_r[WIDTH-2:0], 1'b0};
      if (!diff[WIDTH]) begin
        rem_nxt = diff[WIDTH-1:0];
      end else begin
        rem_nxt = trial[WIDTH-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/jacobi_symbol_unit_core.sv =====
// Top level of the Jacobi symbol unit: sequencer around a bit-serial divider.
//
// The unit takes a numerator and an odd modulus when start is high and busy is
// low, and when the item is finished shows the Jacobi symbol on out_symbol for
// exactly one cycle, marked by out_valid; the receiver cannot stall, so the
// transfer completes in that cycle. One item is worked on at a time. Each
// factor of two is stripped from the numerator in its own step. Each reduction
// step runs the restoring divider, which produces one quotient bit per cycle:
// it is launched from ST_DIV, and its registered remainder is taken in ST_WAIT
// when the divider reports done. Finding the numerator odd leads to the swap
// step. An item is thus a run of reciprocity steps, each made of the strip,
// swap and reduction, ended by the final zero test and ST_DONE, which
// registers the result that is then shown.
// Only the low WIDTH bits of each input are used.
module jacobi_symbol_unit_core import jsu_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_top_value,
  input  logic [63:0] in_modulus,
  output logic        out_valid,
  output logic [1:0]  out_symbol
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STRIP = 3'd1;
  localparam logic [2:0] ST_SWAP  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] n_r, n_nxt;
  logic             neg_r, neg_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       sym_r, sym_nxt;
  jsu_div_ctl_t     dctl;
  jsu_div_sts_t     dsts;
  logic [WIDTH-1:0] drem;
  logic             n_is_one;

  assign n_is_one = (n_r == WIDTH'(1));

  // Remainder unit: a mod n, where n is the odd former a and never zero.
  jsu_div #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (dctl),
    .dividend  (a_r),
    .divisor   (n_r),
    .sts       (dsts),
    .remainder (drem)
  );

  always_comb begin
    st_nxt     = st_r;
    a_nxt      = a_r;
    n_nxt      = n_r;
    neg_nxt    = neg_r;
    ov_nxt     = 1'b0;
    sym_nxt    = sym_r;
    dctl.start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt   = in_top_value[WIDTH-1:0];
          n_nxt   = in_modulus[WIDTH-1:0];
          neg_nxt = 1'b0;
          st_nxt  = ST_STRIP;
        end
      end
      ST_STRIP: begin
        // A zero numerator ends the loop; an even one loses one factor of two, an odd one goes on to the swap.
        if (a_r == '0) begin
          st_nxt = ST_DONE;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
          if (n_r[2:0] == 3'd3 || n_r[2:0] == 3'd5) begin
            neg_nxt = ~neg_r;
          end
        end else begin
          st_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        a_nxt = n_r;
        n_nxt = a_r;
        if (a_r[1:0] == 2'b11 && n_r[1:0] == 2'b11) begin
          neg_nxt = ~neg_r;
        end
        st_nxt = ST_DIV;
      end
      ST_DIV: begin
        dctl.start = 1'b1;
        st_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (dsts.done) begin
          a_nxt  = drem;
          st_nxt = ST_STRIP;
        end
      end
      ST_DONE: begin
        ov_nxt  = 1'b1;
        sym_nxt = !n_is_one ? SYM_ZERO : (neg_r ? SYM_NEG : SYM_POS);
        st_nxt  = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    n_r   <= n_nxt;
    neg_r <= neg_nxt;
    sym_r <= sym_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign busy       = (st_r != ST_IDLE);
  assign out_valid  = ov_r;
  assign out_symbol = sym_r;

  // A result is shown only in the cycle after the final step of an item.
  a_res_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r) == ST_DONE) else $error("result without finish");

  // The divisor handed to the remainder unit is odd, hence never zero.
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> n_r[0]) else $error("even divisor");

  // The symbol is always one of the three defined codes.
  a_sym_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_symbol == SYM_ZERO || out_symbol == SYM_POS ||
                   out_symbol == SYM_NEG)) else $error("bad symbol code");

  // The divider reports completion only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dsts.done |-> st_r == ST_WAIT) else $error("stray divider completion");

endmodule

// ===== bench/jacobi_symbol_unit_core_tb.sv =====
// Self-checking testbench for the Jacobi symbol unit: directed table plus random operand pairs.
`timescale 1ns / 1ps

module jacobi_symbol_unit_core_tb import jsu_pkg::*;;

  localparam int WIDTH = 64;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM = 118;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_top_value;
  logic [63:0] in_modulus;
  logic        out_valid;
  logic [1:0]  out_symbol;

  // Expected symbols, oldest first. One is queued per accepted transfer.
  logic [1:0] symbol_queue[$];
  int         mismatches;

  // One row of the directed table. When has_sym is set the expected symbol is
  // the typed-in one, and it is also cross-checked against the predictor.
  typedef struct {
    logic [63:0] a;
    logic [63:0] n;
    bit          has_sym;
    logic [1:0]  sym;
  } jacobi_row_t;

  jacobi_row_t directed_rows[N_DIRECTED];

  jacobi_symbol_unit_core #(.WIDTH(WIDTH)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_top_value (in_top_value),
    .in_modulus   (in_modulus),
    .out_valid    (out_valid),
    .out_symbol   (out_symbol)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reciprocity loop on WIDTH-bit operands; returns the two-bit symbol code.
  function automatic logic [1:0] jacobi_symbol(logic [63:0] a_in, logic [63:0] n_in);
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] t;
    bit          negative;
    mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
    a = a_in & mask;
    n = n_in & mask;
    negative = 1'b0;
    while (a != 0) begin
      while (a[0] == 1'b0) begin
        a = a >> 1;
        if (n[2:0] == 3'd3 || n[2:0] == 3'd5) negative = ~negative;
      end
      t = a;
      a = n;
      n = t;
      if (a[1:0] == 2'd3 && n[1:0] == 2'd3) negative = ~negative;
      a = a % n;
    end
    if (n != 64'd1) return SYM_ZERO;
    return negative ? SYM_NEG : SYM_POS;
  endfunction

  // Random 64-bit operand; sizes are mixed so that short and long reduction
  // chains both occur, and every bit gets exercised at both values.
  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: v = v & 64'hFF;
      1: v = v & 64'hFFFF_FFFF;
      default: ;
    endcase
    return v;
  endfunction

  // Presents one operand pair, holds start until the unit takes it, and queues
  // the expected symbol. Start stays high between back-to-back items.
  task automatic send_pair(logic [63:0] a, logic [63:0] n, bit typed, logic [1:0] sym,
                           bit allow_gap);
    logic [1:0] predicted;
    int         gap;
    predicted = jacobi_symbol(a, n);
    if (typed && predicted !== sym)
      $display("%0t: table row disagrees with predictor for a=%h n=%h: expected %0d actual %0d",
               $time, a, n, sym, predicted);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_top_value <= a;
    in_modulus   <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The transfer happened at this edge.
    symbol_queue.push_back(typed ? sym : predicted);
  endtask

  // Results cannot be held off, so each strobe is checked at the edge that
  // ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (symbol_queue.size() == 0) begin
        $display("%0t: unexpected symbol: expected none actual %b", $time, out_symbol);
        mismatches++;
      end else begin
        if (out_symbol !== symbol_queue[0]) begin
          $display("%0t: symbol mismatch: expected %b actual %b",
                   $time, symbol_queue[0], out_symbol);
          mismatches++;
        end
        void'(symbol_queue.pop_front());
      end
    end
  end

  initial begin
    int          i;
    int          settle;
    logic [63:0] a;
    logic [63:0] n;
    // Zero numerator, unit modulus, extremes, even and zero moduli, and a few
    // textbook values.
    directed_rows = '{
      '{64'd0,    64'd1,    1'b1, SYM_POS},
      '{64'd0,    64'd3,    1'b1, SYM_ZERO},
      '{64'd0,    64'd0,    1'b1, SYM_ZERO},
      '{64'd1,    64'd1,    1'b1, SYM_POS},
      '{64'd5,    64'd0,    1'b0, SYM_ZERO},
      '{64'd3,    64'd5,    1'b1, SYM_NEG},
      '{64'd2,    64'd7,    1'b1, SYM_POS},
      '{64'd2,    64'd3,    1'b1, SYM_NEG},
      '{64'd6,    64'd9,    1'b1, SYM_ZERO},
      '{64'd1001, 64'd9907, 1'b1, SYM_NEG},
      '{64'd19,   64'd45,   1'b1, SYM_POS},
      '{64'd8,    64'd21,   1'b1, SYM_NEG},
      '{64'd7,    64'd8,    1'b0, SYM_ZERO},
      '{64'd12,   64'd10,   1'b0, SYM_ZERO},
      '{'1,       '1,       1'b1, SYM_ZERO},
      '{'1,       64'd1,    1'b1, SYM_POS},
      '{64'd1,    '1,       1'b1, SYM_POS},
      '{64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5, 1'b0, SYM_ZERO},
      '{'1,       64'hFFFF_FFFF_FFFF_FFC5, 1'b0, SYM_ZERO},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, SYM_ZERO},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0, SYM_ZERO},
      '{'1,       64'h8000_0000_0000_0000, 1'b0, SYM_ZERO}
    };
    mismatches    = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_top_value  = '0;
    in_modulus    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++)
      send_pair(directed_rows[i].a, directed_rows[i].n, directed_rows[i].has_sym,
                directed_rows[i].sym, 1'b1);

    // Mostly odd moduli as intended use; a quarter are even or arbitrary.
    // The last stretch runs without idle gaps.
    for (i = 0; i < N_RANDOM; i++) begin
      a = random_operand();
      n = random_operand();
      if ($urandom_range(0, 3) != 0) n[0] = 1'b1;
      send_pair(a, n, 1'b0, SYM_ZERO, i < N_RANDOM - 30);
    end
    start <= 1'b0;

    settle = 0;
    while (symbol_queue.size() != 0 && settle < 200000) begin
      @(posedge clk);
      settle++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && symbol_queue.size() == 0)
      $display("jacobi_symbol_unit_core verification clean");
    else
      $display("jacobi_symbol_unit_core verification failed");
    $finish;
  end

  // Generous ceiling: room for all 140 items at their longest, several times over.
  initial begin
    #60_000_000;
    $display("jacobi_symbol_unit_core verification failed");
    $finish;
  end

endmodule
